[rtl/sumset_productset_size_macros.svh]
// assertion shorthands for the checker file
`ifndef SUMSET_PRODUCTSET_SIZE_MACROS_SVH
`define SUMSET_PRODUCTSET_SIZE_MACROS_SVH

// consequent checked in the same cycle
`define SSPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssps_pkg.sv]
package ssps_pkg;

    // register and result field widths
    localparam int CFG_W       = 6;
    localparam int SUM_CNT_W   = 7;
    localparam int PROD_CNT_W  = 11;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_CNT_W - PROD_CNT_W;

    // product bitmap word width and bit-index width
    localparam int WORD_W     = 64;
    localparam int WORD_BIT_W = 6;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

[rtl/ssps_ram.sv]
module ssps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 63
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sumset_productset_size.sv]
// channel   dir  width  beat contents (low bit first)
// s_axis    in   64     set_mask[62:0], zero pad
// m_axis    out  24     sum_count[6:0], product_count[10:0], zero pad
// cfg       in   6      max_element, taken whenever cfg_we is high
//
// one set at a time: a single 6x6 multiply/add unit walks the element pairs
// a <= b of the set; each member pair passes through multiply, bitmap word
// read and read-modify-write steps, each skipped pair or row through the scan
// step alone, and each set also has an entry and an exit step.
// reset clears the sequencer, output valid, bitmap valid bits, max_element=63.
// a finished result sits in the output register; the next set is accepted
// while it waits, and only the exit step stalls until that register frees.
module sumset_productset_size #(
    parameter int MAX_N = 63
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // set_mask[MAX_N-1:0], zero pad
    input  logic [((MAX_N + 7) / 8) * 8 - 1:0]  s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sum_count[6:0], product_count[10:0], zero pad
    output logic [ssps_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [ssps_pkg::CFG_W-1:0]          cfg_wdata
);

    import ssps_pkg::*;

    localparam int EW         = $clog2(MAX_N + 1);
    localparam int SW         = EW + 1;
    localparam int PW         = 2 * EW;
    localparam int PXW        = (PW > WORD_BIT_W) ? PW : WORD_BIT_W + 1;
    localparam int SMAP_W     = 2 * MAX_N + 1;
    localparam int PMAP_DEPTH = (MAX_N * MAX_N) / WORD_W + 1;
    localparam int AW         = (PMAP_DEPTH > 1) ? $clog2(PMAP_DEPTH) : 1;

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        max_n_reg, max_n_next;
    logic [EW-1:0]           n_clamp;
    logic [EW-1:0]           n_eff_reg, n_eff_next;
    logic [MAX_N-1:0]        mask_reg, mask_next;
    logic [EW-1:0]           a_reg, a_next;
    logic [EW-1:0]           b_reg, b_next;
    logic [SW-1:0]           sum_reg, sum_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [SMAP_W-1:0]       sum_map_reg, sum_map_next;
    logic [PMAP_DEPTH-1:0]   pvalid_reg, pvalid_next;
    logic [SUM_CNT_W-1:0]    sum_cnt_reg, sum_cnt_next;
    logic [PROD_CNT_W-1:0]   prod_cnt_reg, prod_cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SUM_CNT_W-1:0]    out_sum_reg, out_sum_next;
    logic [PROD_CNT_W-1:0]   out_prod_reg, out_prod_next;

    logic [EW-1:0]           a_idx, b_idx;
    logic                    a_member, b_member;
    logic                    row_last, col_last;
    logic [PXW-1:0]          prod_x;
    logic [AW-1:0]           word_addr;
    logic [WORD_BIT_W-1:0]   bit_idx;
    logic [WORD_W-1:0]       rd_word, old_word, new_word;
    logic                    prod_seen, sum_seen;
    logic                    ram_we;

    // clamp the configured ground-set size to what the block was built for
    assign n_clamp = (max_n_reg > CFG_W'(MAX_N)) ? EW'(MAX_N) : EW'(max_n_reg);

    // pair walk helpers
    assign a_idx    = a_reg - EW'(1);
    assign b_idx    = b_reg - EW'(1);
    assign a_member = mask_reg[a_idx];
    assign b_member = mask_reg[b_idx];
    assign row_last = (a_reg == n_eff_reg);
    assign col_last = (b_reg == n_eff_reg);

    // product bitmap addressing
    assign prod_x    = PXW'(prod_reg);
    assign word_addr = AW'(prod_x[PXW-1:WORD_BIT_W]);
    assign bit_idx   = prod_x[WORD_BIT_W-1:0];
    assign old_word  = pvalid_reg[word_addr] ? rd_word : '0;
    assign prod_seen = old_word[bit_idx];
    assign new_word  = old_word | (WORD_W'(1) << bit_idx);
    assign sum_seen  = sum_map_reg[sum_reg];
    assign ram_we    = (state_reg == ST_UPDATE);

    ssps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PMAP_DEPTH)
    ) u_prod_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_addr),
        .wdata (new_word),
        .raddr (word_addr),
        .rdata (rd_word)
    );

    // sequencer: next state and datapath updates
    always_comb
    begin
        logic advance;
        logic next_row;

        state_next    = state_reg;
        max_n_next    = cfg_we ? cfg_wdata : max_n_reg;
        n_eff_next    = n_eff_reg;
        mask_next     = mask_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        sum_next      = sum_reg;
        prod_next     = prod_reg;
        sum_map_next  = sum_map_reg;
        pvalid_next   = pvalid_reg;
        sum_cnt_next  = sum_cnt_reg;
        prod_cnt_next = prod_cnt_reg;
        out_sum_next  = out_sum_reg;
        out_prod_next = out_prod_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        advance       = 1'b0;
        next_row      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mask_next     = s_tdata[MAX_N-1:0];
                    n_eff_next    = n_clamp;
                    a_next        = EW'(1);
                    b_next        = EW'(1);
                    sum_map_next  = '0;
                    pvalid_next   = '0;
                    sum_cnt_next  = '0;
                    prod_cnt_next = '0;
                    state_next    = (n_clamp == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!a_member)
                begin
                    advance  = 1'b1;
                    next_row = 1'b1;
                end
                else if (!b_member)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    // shared unit: one multiply and one add per member pair
                    prod_next  = PW'(a_reg) * PW'(b_reg);
                    sum_next   = SW'(a_reg) + SW'(b_reg);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // mark both bitmaps and count first-time hits
                sum_map_next[sum_reg]  = 1'b1;
                pvalid_next[word_addr] = 1'b1;
                if (!sum_seen)
                begin
                    sum_cnt_next = sum_cnt_reg + SUM_CNT_W'(1);
                end
                if (!prod_seen)
                begin
                    prod_cnt_next = prod_cnt_reg + PROD_CNT_W'(1);
                end
                advance = 1'b1;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_sum_next  = sum_cnt_reg;
                    out_prod_next = prod_cnt_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next pair a <= b
        if (advance)
        begin
            if (next_row || col_last)
            begin
                if (row_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    a_next     = a_reg + EW'(1);
                    b_next     = a_reg + EW'(1);
                    state_next = ST_SCAN;
                end
            end
            else
            begin
                b_next     = b_reg + EW'(1);
                state_next = ST_SCAN;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_n_reg    <= CFG_W'(63);
            pvalid_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            max_n_reg    <= max_n_next;
            pvalid_reg   <= pvalid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_eff_reg    <= n_eff_next;
        mask_reg     <= mask_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        sum_map_reg  <= sum_map_next;
        sum_cnt_reg  <= sum_cnt_next;
        prod_cnt_reg <= prod_cnt_next;
        out_sum_reg  <= out_sum_next;
        out_prod_reg <= out_prod_next;
    end

    // port drive
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_prod_reg, out_sum_reg};

endmodule

[rtl/ssps_check.sv]
`include "sumset_productset_size_macros.svh"

module ssps_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ssps_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import ssps_pkg::*;

    // an accepted set closes the input in the cycle after the beat
    `SSPS_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "input open after beat")

    // a stalled result beat holds
    `SSPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // sum count stays within the sumset bound
    `SSPS_ASSERT_SAME(a_sum_range, m_tvalid, m_tdata[SUM_CNT_W-1:0] <= SUM_CNT_W'(125), "sum count out of range")

    // both counts are zero together, for an empty set only
    `SSPS_ASSERT_SAME(a_empty_match, m_tvalid, (m_tdata[SUM_CNT_W-1:0] == '0) == (m_tdata[SUM_CNT_W+PROD_CNT_W-1:SUM_CNT_W] == '0), "counts disagree on empty set")

endmodule

bind sumset_productset_size ssps_check u_ssps_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssps_pkg::*;

    localparam int MASK_W       = 63;
    localparam int KEEP_N       = -1;     // row leaves max_element as it is
    localparam int ITEMS_PER_PH = 36;
    localparam int NUM_PHASES   = 8;
    localparam int QUIET_LIMIT  = 40000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 6200;   // worst-case time for one set

    localparam logic [MASK_W-1:0] FULL_SET = 63'h7FFF_FFFF_FFFF_FFFF;

    // the two counts, sum_count in the low bits as on m_tdata
    typedef struct packed {
        logic [PROD_CNT_W-1:0] prod_cnt;
        logic [SUM_CNT_W-1:0]  sum_cnt;
    } counts_t;

    // one directed row: optional register write, then one set
    typedef struct packed {
        int                    cfg_n;
        logic [MASK_W-1:0]     mask;
        bit                    known;
        logic [SUM_CNT_W-1:0]  sum_cnt;
        logic [PROD_CNT_W-1:0] prod_cnt;
    } stim_row_t;

    localparam int NUM_ROWS = 16;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // reset value n = 63
        '{KEEP_N, 63'h0,                   1'b1, 7'd0, 11'd0},
        '{KEEP_N, FULL_SET,                1'b0, 7'd0, 11'd0},
        '{KEEP_N, 63'h1,                   1'b1, 7'd1, 11'd1},
        '{KEEP_N, 63'h4000_0000_0000_0000, 1'b1, 7'd1, 11'd1},
        '{KEEP_N, 63'h4000_0000_0000_0001, 1'b1, 7'd3, 11'd3},
        '{KEEP_N, 63'h6,                   1'b1, 7'd3, 11'd3},
        '{KEEP_N, 63'h1555_5555_5555_5555, 1'b0, 7'd0, 11'd0},
        '{KEEP_N, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 7'd0, 11'd0},
        '{KEEP_N, 63'h7F00_0000_0000_0000, 1'b0, 7'd0, 11'd0},
        // n = 0 ignores every bit
        '{0,      FULL_SET,                1'b1, 7'd0, 11'd0},
        '{KEEP_N, 63'h1,                   1'b1, 7'd0, 11'd0},
        // n = 1 keeps only element 1
        '{1,      FULL_SET,                1'b1, 7'd1, 11'd1},
        '{KEEP_N, 63'h7FFF_FFFF_FFFF_FFFE, 1'b1, 7'd0, 11'd0},
        // n = 5
        '{5,      FULL_SET,                1'b0, 7'd0, 11'd0},
        '{KEEP_N, 63'h20,                  1'b1, 7'd0, 11'd0},
        // back to the top of the range
        '{63,     63'h0123_4567_89AB_CDEF, 1'b0, 7'd0, 11'd0}
    };

    // register value of each random phase
    localparam int PHASE_N [NUM_PHASES] = '{63, 9, 1, 40, 63, 20, 3, 50};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [63:0]            s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // predictor copy of max_element
    logic [CFG_W-1:0] ground_n = 6'd63;

    counts_t pending_counts [$];
    int      src_idle_pct = 0;
    int      rx_stall_pct = 0;
    int      sets_sent = 0;
    int      counts_seen = 0;
    int      errors = 0;
    int      quiet_cycles = 0;

    sumset_productset_size #(
        .MAX_N (63)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // distinct pairwise sums and products of the members up to n
    function automatic counts_t count_sumset_productset(input logic [MASK_W-1:0] mask,
                                                        input logic [CFG_W-1:0] n);
        bit [127:0]  sum_seen;
        bit [4095:0] prod_seen;
        counts_t     c;
        sum_seen  = '0;
        prod_seen = '0;
        for (int i = 0; i < int'(n); i++) begin
            if (mask[i]) begin
                for (int j = i; j < int'(n); j++) begin
                    if (mask[j]) begin
                        sum_seen[i + j + 2]         = 1'b1;
                        prod_seen[(i + 1) * (j + 1)] = 1'b1;
                    end
                end
            end
        end
        c.sum_cnt  = SUM_CNT_W'($countones(sum_seen));
        c.prod_cnt = PROD_CNT_W'($countones(prod_seen));
        return c;
    endfunction

    // random set, mixing sparse, dense and fully random masks
    function automatic logic [MASK_W-1:0] random_set();
        logic [63:0]       raw;
        logic [MASK_W-1:0] m;
        int                pct;
        raw = {$urandom, $urandom};
        m   = raw[MASK_W-1:0];
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(2))
                0:       pct = 8;
                1:       pct = 85;
                default: pct = $urandom_range(100);
            endcase
            for (int i = 0; i < MASK_W; i++)
                m[i] = ($urandom_range(99) < pct);
        end
        return m;
    endfunction

    // send one set and queue its counts once the beat is taken
    task automatic push_set(input logic [MASK_W-1:0] mask, input bit known,
                            input counts_t typed);
        counts_t want;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, mask};
        want = known ? typed : count_sumset_productset(mask, ground_n);
        do @(posedge clk); while (s_tready !== 1'b1);
        pending_counts.push_back(want);
        sets_sent++;
    endtask

    // register write once every queued result has come back
    task automatic set_max_element(input logic [CFG_W-1:0] n);
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        ground_n  = n;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic note_error(input string what, input counts_t want, input counts_t got);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s: expected sum %0d prod %0d, got sum %0d prod %0d",
                     $realtime, what, want.sum_cnt, want.prod_cnt, got.sum_cnt, got.prod_cnt);
    endtask

    // result side: check each beat, random stalls, watchdog
    always @(posedge clk) begin : rx_side
        counts_t got;
        counts_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[SUM_CNT_W + PROD_CNT_W - 1:0];
                counts_seen++;
                if (pending_counts.size() == 0) begin
                    note_error("result beat with nothing pending", '0, got);
                end
                else begin
                    want = pending_counts.pop_front();
                    if (got.sum_cnt !== want.sum_cnt)
                        note_error("sum_count mismatch", want, got);
                    else if (got.prod_cnt !== want.prod_cnt)
                        note_error("product_count mismatch", want, got);
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_counts.size());
            $display("sumset_productset_size test failed");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        counts_t typed;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg_n != KEEP_N)
                set_max_element(CFG_W'(directed_rows[r].cfg_n));
            typed.sum_cnt  = directed_rows[r].sum_cnt;
            typed.prod_cnt = directed_rows[r].prod_cnt;
            push_set(directed_rows[r].mask, directed_rows[r].known, typed);
        end

        // random phases: free-running, sender gaps, receiver stalls, both
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_max_element(CFG_W'(PHASE_N[p]));
            case (p % 4)
                0:       begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin src_idle_pct = 68; rx_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin src_idle_pct = 36; rx_stall_pct = 36; end
            endcase
            for (int k = 0; k < ITEMS_PER_PH; k++)
                push_set(random_set(), 1'b0, '0);
        end

        // drain, then watch for stray beats
        s_tvalid <= 1'b0;
        rx_stall_pct = 0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d sets sent, %0d result beats checked, max_element swept over 0..63",
                 sets_sent, counts_seen);
        $display("idle modes: none, sender gaps, receiver stalls, both sides; %0d errors",
                 errors);
        if (errors == 0)
            $display("sumset_productset_size test passed");
        else
            $display("sumset_productset_size test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ssps_pkg.sv
rtl/ssps_ram.sv
rtl/sumset_productset_size.sv
rtl/ssps_check.sv
bench/testbench.sv
